@@ hw/rtl/robl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// robl_pkg
// Shared codes and widths for the recency ordered block list.
// ----------------------------------------------------------------------------
package robl_pkg;
  localparam int DEFAULT_CAPACITY = 64;

  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_DELETE   = 2'd1;
  localparam logic [1:0] OP_FIND_EQ  = 2'd2;
  localparam logic [1:0] OP_FIND_GE  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // Payload of one record as kept in the record memory.
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] size;
    logic [31:0] address;
  } record_t;
endpackage
`default_nettype wire

@@ hw/rtl/robl_free_map.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// robl_free_map
// Slot valid bits and lowest free slot search, one slice of slots a cycle.
// ----------------------------------------------------------------------------
module robl_free_map import robl_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY,
  localparam int SW = $clog2(CAPACITY + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               done,
  output logic [SW-1:0]      free_slot,
  input  wire logic          set_en,
  input  wire logic          clr_en,
  input  wire logic [SW-1:0] upd_slot
);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SLICE = 8;
  localparam int NSL = (CAPACITY + SLICE - 1) / SLICE;
  localparam int CW = $clog2(NSL + 1);

  logic [CAPACITY-1:0] valid;
  logic                busy;
  logic [CW-1:0]       sl;
  logic                hit;
  logic [SW-1:0]       hit_slot;

  // Search the current slice of eight slots.
  always_comb begin
    int idx;
    hit = 1'b0;
    hit_slot = SW'(CAPACITY);
    for (int j = SLICE - 1; j >= 0; j--) begin
      idx = int'(sl) * SLICE + j;
      if (idx < CAPACITY) begin
        if (!valid[idx]) begin
          hit = 1'b1;
          hit_slot = SW'(idx);
        end
      end
    end
  end

  // Valid bits and scan control.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      busy <= 1'b0;
      sl <= '0;
      done <= 1'b0;
    end else begin
      if (set_en) valid[upd_slot[IW-1:0]] <= 1'b1;
      else if (clr_en) valid[upd_slot[IW-1:0]] <= 1'b0;
      done <= !start && busy && (hit || int'(sl) == NSL - 1);
      if (start) begin
        busy <= 1'b1;
        sl <= '0;
      end else if (busy) begin
        if (hit || int'(sl) == NSL - 1) begin
          busy <= 1'b0;
          free_slot <= hit_slot;
        end else begin
          sl <= sl + CW'(1);
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/robl_node_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// robl_node_mem
// Record and link memories, one write and one registered read port each.
// ----------------------------------------------------------------------------
module robl_node_mem import robl_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY,
  localparam int SW = $clog2(CAPACITY + 1)
) (
  input  wire logic          clk,
  input  wire logic [SW-1:0] rd_slot,
  output record_t            rd_rec,
  output logic [SW-1:0]      rd_next,
  output logic [SW-1:0]      rd_prev,
  input  wire logic          rec_we,
  input  wire logic [SW-1:0] rec_slot,
  input  wire record_t       rec_data,
  input  wire logic          nx_we,
  input  wire logic [SW-1:0] nx_slot,
  input  wire logic [SW-1:0] nx_data,
  input  wire logic          pv_we,
  input  wire logic [SW-1:0] pv_slot,
  input  wire logic [SW-1:0] pv_data
);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  record_t       rec_mem [CAPACITY];
  logic [SW-1:0] nx_mem [CAPACITY];
  logic [SW-1:0] pv_mem [CAPACITY];

  // Synchronous writes and registered reads.
  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_slot[IW-1:0]] <= rec_data;
    if (nx_we) nx_mem[nx_slot[IW-1:0]] <= nx_data;
    if (pv_we) pv_mem[pv_slot[IW-1:0]] <= pv_data;
    rd_rec <= rec_mem[rd_slot[IW-1:0]];
    rd_next <= nx_mem[rd_slot[IW-1:0]];
    rd_prev <= pv_mem[rd_slot[IW-1:0]];
  end
endmodule
`default_nettype wire

@@ hw/rtl/recency_ordered_block_list_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// recency_ordered_block_list_top
// Bounded newest-first list of block records with insert, delete and search.
// ----------------------------------------------------------------------------
// One item is handled at a time. Insert runs the free-slot scan over eight
// valid bits a cycle, then links the old head back and loads the result.
// Delete and both finds walk the linked list through the node memory,
// each record visited taking a registered read, then a compare.
// A result waits in the output register; the next item is taken meanwhile.
// Valid bits clear at reset; no clearing pass is needed.
module recency_ordered_block_list_top import robl_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY,
  localparam int SW = $clog2(CAPACITY + 1)
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // operation[1:0], block_address[33:2], block_size[65:34], search_key[97:66]
  input  wire logic [103:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // status[1:0], found_address[33:2], found_size[65:34], found_key[97:66]
  output logic [103:0]      m_tdata
);
  localparam logic [SW-1:0] NULLS = SW'(CAPACITY);
  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_READ = 3'd2,
                         S_CMP = 3'd3, S_FIX = 3'd4, S_DONE = 3'd5,
                         S_LINK = 3'd6;

  logic [2:0]    state;
  logic [1:0]    op;
  record_t       req;
  logic [SW-1:0] head, count, node, steps;
  logic [SW-1:0] n_save, p_save;
  logic          out_full;

  logic          fm_start, fm_done;
  logic [SW-1:0] fm_slot;
  logic          set_en, clr_en;
  logic [SW-1:0] upd_slot;
  record_t       rd_rec;
  logic [SW-1:0] rd_next, rd_prev;
  logic          rec_we, nx_we, pv_we;
  logic [SW-1:0] rec_slot, nx_slot, pv_slot, nx_data, pv_data;
  logic          hit;
  logic [1:0]    res_st;
  record_t       res_rec;

  robl_free_map #(.CAPACITY(CAPACITY)) u_free (
    .clk, .rst, .start(fm_start), .done(fm_done), .free_slot(fm_slot),
    .set_en, .clr_en, .upd_slot);

  robl_node_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk, .rd_slot(node), .rd_rec, .rd_next, .rd_prev,
    .rec_we, .rec_slot, .rec_data(req), .nx_we, .nx_slot, .nx_data,
    .pv_we, .pv_slot, .pv_data);

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_full;

  // Match test on the record just read.
  always_comb begin
    case (op)
      OP_DELETE: hit = (rd_rec == req);
      OP_FIND_EQ: hit = (rd_rec.key == req.key);
      default: hit = (rd_rec.key >= req.key);
    endcase
  end

  // Memory and valid-bit write strobes per state.
  always_comb begin
    fm_start = 1'b0; set_en = 1'b0; clr_en = 1'b0; upd_slot = node;
    rec_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0;
    rec_slot = fm_slot; nx_slot = node; pv_slot = node;
    nx_data = NULLS; pv_data = NULLS;
    unique case (state)
      S_IDLE: fm_start = s_tvalid && s_tready &&
                         (s_tdata[1:0] == OP_INSERT) && (count != NULLS);
      S_SCAN: if (fm_done && fm_slot != NULLS) begin
        set_en = 1'b1; upd_slot = fm_slot;
        rec_we = 1'b1;
        nx_we = 1'b1; nx_slot = fm_slot; nx_data = head;
        pv_we = 1'b1; pv_slot = fm_slot; pv_data = NULLS;
      end
      S_LINK: if (n_save != NULLS) begin
        pv_we = 1'b1; pv_slot = n_save; pv_data = p_save;
      end
      S_FIX: begin
        clr_en = 1'b1;
        if (p_save != NULLS) begin
          nx_we = 1'b1; nx_slot = p_save; nx_data = n_save;
        end
        if (n_save != NULLS) begin
          pv_we = 1'b1; pv_slot = n_save; pv_data = p_save;
        end
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; head <= NULLS; count <= '0; out_full <= 1'b0;
      node <= NULLS;
    end else begin
      // The output register is loaded in the done state, else it drains.
      if (state == S_DONE) begin
        if (!out_full || m_tready) out_full <= 1'b1;
      end else if (m_tready) begin
        out_full <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (s_tvalid) begin
          op <= s_tdata[1:0];
          req.address <= s_tdata[33:2];
          req.size <= s_tdata[65:34];
          req.key <= s_tdata[97:66];
          steps <= '0;
          node <= head;
          if (s_tdata[1:0] == OP_INSERT) begin
            if (count == NULLS) begin
              res_st <= ST_FULL; res_rec <= '0; state <= S_DONE;
            end else state <= S_SCAN;
          end else if (head == NULLS) begin
            res_st <= ST_NOTFOUND; res_rec <= '0; state <= S_DONE;
          end else state <= S_READ;
        end
        S_SCAN: if (fm_done) begin
          if (fm_slot == NULLS) begin
            res_st <= ST_FULL; res_rec <= '0;
            state <= S_DONE;
          end else begin
            // The old head gets its back link to the new slot next cycle.
            head <= fm_slot;
            count <= count + SW'(1);
            res_st <= ST_OK; res_rec <= req;
            n_save <= head; p_save <= fm_slot;
            state <= S_LINK;
          end
        end
        S_LINK: state <= S_DONE;
        S_READ: state <= S_CMP;
        S_CMP: begin
          if (hit) begin
            res_st <= ST_OK; res_rec <= rd_rec;
            if (op == OP_DELETE) begin
              n_save <= rd_next; p_save <= rd_prev;
              if (rd_prev == NULLS) head <= rd_next;
              if (count != '0) count <= count - SW'(1);
              state <= S_FIX;
            end else state <= S_DONE;
          end else if (rd_next == NULLS || steps == NULLS - SW'(1)) begin
            res_st <= ST_NOTFOUND; res_rec <= '0; state <= S_DONE;
          end else begin
            node <= rd_next; steps <= steps + SW'(1); state <= S_READ;
          end
        end
        S_FIX: state <= S_DONE;
        S_DONE: if (!out_full || m_tready) begin
          m_tdata <= {6'd0, res_rec.key, res_rec.size, res_rec.address, res_st};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ tb/recency_ordered_block_list_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// recency_ordered_block_list_top_test
// Drives insert, delete and search operations into the block list and checks
// every result against a behavioral list kept in the testbench.
// ----------------------------------------------------------------------------
module recency_ordered_block_list_top_test;
  import robl_pkg::*;

  localparam int CAP = DEFAULT_CAPACITY;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] address;
    logic [31:0] size;
    logic [31:0] key;
  } answer_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;

  recency_ordered_block_list_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  // Behavioral list: newest record at index 0, slot numbers irrelevant.
  logic [31:0] list_addr[$];
  logic [31:0] list_size[$];
  logic [31:0] list_key[$];
  answer_t     pending_answers[$];

  int  fail_count = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_off_cycles = 0;
  longint cycle_count = 0;

  // Computes the answer of one operation and updates the list.
  function automatic answer_t apply_operation(logic [1:0] op, logic [31:0] a,
                                              logic [31:0] s, logic [31:0] k);
    answer_t r;
    int      hit;
    bit      m;
    r = '0;
    r.status = ST_NOTFOUND;
    hit = -1;
    if (op == OP_INSERT) begin
      if (list_key.size() >= CAP) begin
        r.status = ST_FULL;
      end else begin
        list_addr.push_front(a);
        list_size.push_front(s);
        list_key.push_front(k);
        r = '{ST_OK, a, s, k};
      end
      return r;
    end
    for (int i = 0; i < list_key.size(); i++) begin
      if (op == OP_DELETE) m = list_addr[i] == a && list_size[i] == s && list_key[i] == k;
      else if (op == OP_FIND_EQ) m = list_key[i] == k;
      else m = list_key[i] >= k;
      if (m) begin
        hit = i;
        break;
      end
    end
    if (hit >= 0) begin
      r = '{ST_OK, list_addr[hit], list_size[hit], list_key[hit]};
      if (op == OP_DELETE) begin
        list_addr.delete(hit);
        list_size.delete(hit);
        list_key.delete(hit);
      end
    end
    return r;
  endfunction

  // Offers one operation and waits until its transfer completes.
  task automatic send_operation(logic [1:0] op, logic [31:0] a, logic [31:0] s,
                                logic [31:0] k);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, k, s, a, op};
    do @(posedge clk); while (!s_tready);
    pending_answers.push_back(apply_operation(op, a, s, k));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (2 * CAP + 20) @(posedge clk);
  endtask

  // Keys drawn from a small pool so searches and deletes often hit.
  function automatic logic [31:0] pick_value(int pool);
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      2: return 32'd0;
      default: return $urandom_range(pool);
    endcase
  endfunction

  // Receiver readiness, including long hold-off stretches.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each result transfer with the oldest expected answer.
  always @(posedge clk) begin
    answer_t got, want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("recency_ordered_block_list_top test failed");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[1:0], m_tdata[33:2], m_tdata[65:34], m_tdata[97:66]};
      if (pending_answers.size() == 0) begin
        $error("unexpected result transfer %h", m_tdata);
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (got.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, got.status);
          fail_count++;
        end
        if (got.address !== want.address) begin
          $error("found_address expected %h actual %h", want.address, got.address);
          fail_count++;
        end
        if (got.size !== want.size) begin
          $error("found_size expected %h actual %h", want.size, got.size);
          fail_count++;
        end
        if (got.key !== want.key) begin
          $error("found_key expected %h actual %h", want.key, got.key);
          fail_count++;
        end
      end
    end
  end

  // Extremes, empty list, duplicates, every operation, OK and not-found status.
  task automatic test_directed();
    send_operation(OP_DELETE, 0, 0, 0);
    send_operation(OP_FIND_EQ, 0, 0, 0);
    send_operation(OP_FIND_GE, 0, 0, 0);
    send_operation(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operation(OP_INSERT, 0, 0, 0);
    send_operation(OP_INSERT, 32'h1234, 32'h10, 32'd5);
    send_operation(OP_INSERT, 32'h5678, 32'h20, 32'd5);
    send_operation(OP_FIND_EQ, 0, 0, 32'd5);
    send_operation(OP_FIND_GE, 0, 0, 32'd6);
    send_operation(OP_FIND_GE, 0, 0, 32'd1);
    send_operation(OP_FIND_EQ, 0, 0, 32'd7);
    send_operation(OP_DELETE, 32'h1234, 32'h10, 32'd6);
    send_operation(OP_DELETE, 32'h1234, 32'h10, 32'd5);
    send_operation(OP_FIND_EQ, 0, 0, 32'd5);
    send_operation(OP_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operation(OP_FIND_GE, 0, 0, 32'hFFFF_FFFF);
  endtask

  // Fill the list past capacity while the receiver holds off, then empty it.
  task automatic test_full_list();
    hold_off_cycles = 600;
    while (list_key.size() < CAP) send_operation(OP_INSERT, $urandom(), $urandom(),
                                                 $urandom_range(40));
    send_operation(OP_INSERT, 1, 2, 3);
    send_operation(OP_INSERT, 4, 5, 6);
    send_operation(OP_FIND_GE, 0, 0, 32'hFFFF_FFFF);
    wait_drained();
    while (list_key.size() > 0) begin
      int i;
      i = $urandom_range(list_key.size() - 1);
      send_operation(OP_DELETE, list_addr[i], list_size[i], list_key[i]);
    end
    send_operation(OP_FIND_GE, 0, 0, 0);
    wait_drained();
  endtask

  // Random mix; deletes mostly aim at records actually present.
  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      int sel;
      logic [1:0] op;
      sel = $urandom_range(99);
      op = (sel < 40 && list_key.size() < 50) ? OP_INSERT : 2'($urandom_range(1, 3));
      if (sel < 5) op = 2'($urandom());
      if (op == OP_DELETE && list_key.size() > 0 && $urandom_range(3) != 0) begin
        int i;
        i = $urandom_range(list_key.size() - 1);
        send_operation(op, list_addr[i], list_size[i], list_key[i]);
      end else begin
        send_operation(op, pick_value(15), pick_value(15), pick_value(31));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_full_list();
    test_random(420);
    send_idle_pct = 48;
    test_random(420);
    send_idle_pct = 0;
    recv_stall_pct = 48;
    test_random(420);
    send_idle_pct = 21;
    recv_stall_pct = 21;
    test_random(420);
    wait_drained();
    if (fail_count == 0) begin
      $display("recency_ordered_block_list_top test passed");
    end else begin
      $display("recency_ordered_block_list_top test failed");
    end
    $finish;
  end
endmodule
